### rtl/indexed_sequence_store_core_defines.svh
// Assertion macros for the indexed sequence store.
// Expect clk and rst_n in scope at the point of use.
`ifndef INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle.
`define ISS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iss: same-cycle check failed");

// Consequent must hold in the following cycle.
`define ISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iss: next-cycle check failed");

`endif

### rtl/iss_pkg.sv
// Shared types and constants of the indexed sequence store.
// No dependencies.
package iss_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TYPE_W     = 4;
    localparam int POS_W      = 5;
    localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [TYPE_W-1:0] {
        REQ_APPEND     = 4'd0,
        REQ_PREPEND    = 4'd1,
        REQ_INSERT     = 4'd2,
        REQ_DROP_LAST  = 4'd3,
        REQ_DROP_FIRST = 4'd4,
        REQ_REMOVE     = 4'd5,
        REQ_READ       = 4'd6,
        REQ_WRITE      = 4'd7,
        REQ_CLEAR      = 4'd8
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    // Controller to datapath
    typedef struct packed {
        logic              load_req;
        logic              mem_rd;
        logic [ADDR_W-1:0] rd_addr;
        logic              mem_wr;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_shift;
        cnt_op_t           cnt_op;
        logic              out_load;
        logic              out_rd_sel;
        status_t           out_status;
    } iss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
        logic              out_busy;
    } iss_stat_t;

endpackage

### rtl/iss_if.sv
// Request and response channel interfaces of the indexed sequence store.
// Depends on iss_pkg.
interface iss_req_if import iss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TYPE_W-1:0]     req_type;
    logic [POS_W-1:0]      position;
    logic [DATA_WIDTH-1:0] data_in;

    modport source (output valid, output req_type, output position, output data_in,
                    input ready);
    modport sink   (input valid, input req_type, input position, input data_in,
                    output ready);
endinterface

interface iss_rsp_if import iss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_data;
    status_t               status;
    logic [CNT_W-1:0]      count;

    modport source (output valid, output read_data, output status, output count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input count,
                    output ready);
endinterface

### rtl/iss_datapath.sv
// Datapath: request registers, element memory, element count, response register.
// Depends on iss_pkg.
module iss_datapath import iss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iss_cmd_t              cmd,
    output iss_stat_t             stat,
    input  logic [TYPE_W-1:0]     req_type,
    input  logic [POS_W-1:0]      position,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] read_data,
    output status_t               status,
    output logic [CNT_W-1:0]      count
);

    logic [TYPE_W-1:0]     type_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;
    status_t               status_reg;
    logic [CNT_W-1:0]      count_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg <= req_type;
            pos_reg  <= position;
            data_reg <= data_in;
        end
    end

    // Element memory; a shift writes back the word read the cycle before
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[cmd.wr_addr] <= cmd.wr_shift ? rdata_reg : data_reg;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_HOLD:  count_next = count_reg;
            CNT_INC:   count_next = count_reg + 1'b1;
            CNT_DEC:   count_next = count_reg - 1'b1;
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_data_reg <= cmd.out_rd_sel ? rdata_reg : '0;
            status_reg    <= cmd.out_status;
            count_out_reg <= count_reg;
        end
    end

    assign stat.req_type = type_reg;
    assign stat.position = pos_reg;
    assign stat.count    = count_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

### rtl/iss_ctrl.sv
// Controller: decodes a request, runs the element shift loop, issues the response.
// Depends on iss_pkg.
module iss_ctrl import iss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  iss_stat_t stat,
    output iss_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_STEP,
        S_MOVE,
        S_READ,
        S_RESP
    } state_t;

    localparam logic [CNT_W-1:0] CountFull = CNT_W'(DEPTH);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] lim_reg, lim_next;
    logic              open_reg, open_next;
    logic              rd_sel_reg, rd_sel_next;
    status_t           status_reg, status_next;

    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              full;
    logic              empty;
    logic              in_range;

    assign pos_x    = CMP_W'(stat.position);
    assign cnt_x    = CMP_W'(stat.count);
    assign full     = (stat.count == CountFull);
    assign empty    = (stat.count == '0);
    assign in_range = (pos_x < cnt_x);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        open_next   = open_reg;
        rd_sel_next = rd_sel_reg;
        status_next = status_reg;

        cmd            = '0;
        cmd.cnt_op     = CNT_HOLD;
        cmd.out_status = status_reg;
        cmd.out_rd_sel = rd_sel_reg;
        cmd.rd_addr    = stat.position[ADDR_W-1:0];
        cmd.wr_addr    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_req = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_OK;
                rd_sel_next = 1'b0;
                state_next  = S_RESP;
                unique case (stat.req_type) inside
                    REQ_APPEND, REQ_PREPEND, REQ_INSERT:
                    begin
                        if (stat.req_type == REQ_INSERT && pos_x > cnt_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // open a gap: walk down from the end to the target slot
                            open_next  = 1'b1;
                            idx_next   = ADDR_W'(stat.count);
                            state_next = S_STEP;
                            if (stat.req_type == REQ_APPEND)
                            begin
                                lim_next = ADDR_W'(stat.count);
                            end
                            else if (stat.req_type == REQ_PREPEND)
                            begin
                                lim_next = '0;
                            end
                            else
                            begin
                                lim_next = stat.position[ADDR_W-1:0];
                            end
                        end
                    end
                    REQ_DROP_LAST:
                    begin
                        if (empty)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                    end
                    REQ_DROP_FIRST, REQ_REMOVE:
                    begin
                        if ((stat.req_type == REQ_DROP_FIRST && empty) ||
                            (stat.req_type == REQ_REMOVE && !in_range))
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            // close the slot: walk up to the last element
                            open_next  = 1'b0;
                            idx_next   = (stat.req_type == REQ_DROP_FIRST) ? '0 :
                                         stat.position[ADDR_W-1:0];
                            lim_next   = ADDR_W'(stat.count - 1'b1);
                            state_next = S_STEP;
                        end
                    end
                    REQ_READ:
                    begin
                        if (!in_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            rd_sel_next = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    REQ_WRITE:
                    begin
                        if (!in_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.mem_wr  = 1'b1;
                            cmd.wr_addr = stat.position[ADDR_W-1:0];
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
            end

            S_STEP:
            begin
                if (idx_reg == lim_reg)
                begin
                    if (open_reg)
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.cnt_op = CNT_INC;
                    end
                    else
                    begin
                        cmd.cnt_op = CNT_DEC;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_addr = open_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    state_next  = S_MOVE;
                end
            end

            S_MOVE:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_shift = 1'b1;
                idx_next     = open_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                state_next   = S_STEP;
            end

            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            lim_reg    <= '0;
            open_reg   <= 1'b0;
            rd_sel_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            lim_reg    <= lim_next;
            open_reg   <= open_next;
            rd_sel_reg <= rd_sel_next;
            status_reg <= status_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

### rtl/indexed_sequence_store_core.sv
// Write, drop last, clear and rejected requests go from the decode state straight to the
// response state; a read passes a memory read state first; append, prepend, insert,
// drop first and remove run the shift loop, a step and a move state per shifted element.
// One request in flight; the next is taken in the cycle after the response is registered.
// The shift loop is bound by the single read and single write port of the element memory.
// Reset (async, active low) empties the store; element memory contents are not cleared.
`include "indexed_sequence_store_core_defines.svh"

module indexed_sequence_store_core import iss_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    iss_req_if.sink      req,
    iss_rsp_if.source    rsp
);

    localparam logic [CNT_W-1:0] CountFull = CNT_W'(DEPTH);

    iss_cmd_t  cmd;
    iss_stat_t stat;

    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    iss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_type  (req.req_type),
        .position  (req.position),
        .data_in   (req.data_in),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .read_data (rsp.read_data),
        .status    (rsp.status),
        .count     (rsp.count)
    );

    `ISS_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    `ISS_ASSERT_SAME(a_count_bound, 1'b1, stat.count <= CountFull)
    `ISS_ASSERT_SAME(a_full_means_full, rsp.valid && rsp.status == ST_FULL, rsp.count == CountFull)
    `ISS_ASSERT_SAME(a_data_only_ok, rsp.valid && rsp.read_data != '0, rsp.status == ST_OK)

endmodule
